// ----- src/hlc_pkg.sv -----
// ---------------------------------------------------------------------------
// hlc_pkg
// Shared constants, types and plane helpers for the homogeneous line clipper.
// ---------------------------------------------------------------------------
package hlc_pkg;

	localparam int NUM_PLANES    = 6;
	localparam int FIFO_DEPTH    = 4;
	localparam int NUM_COMPS     = 4;
	localparam int NUM_ENDPOINTS = 2;
	localparam int MIN_DEN_W     = 16;

	// component codes inside one endpoint
	localparam int COMP_X = 0;
	localparam int COMP_Y = 1;
	localparam int COMP_Z = 2;
	localparam int COMP_W = 3;

	typedef logic [MIN_DEN_W-1:0] min_den_t;

	localparam min_den_t MIN_DEN_RESET = 16'd1;

	// plane order: w+x, w-x, w+y, w-y, w+z, w-z
	function automatic int plane_axis(input int plane);
		plane_axis = plane / 2;
	endfunction

	function automatic bit plane_minus(input int plane);
		plane_minus = (plane % 2) == 1;
	endfunction

endpackage

// ----- src/hlc_fifo.sv -----
// ---------------------------------------------------------------------------
// hlc_fifo
// Small flop-based queue that decouples the front end from the clip pipeline.
// ---------------------------------------------------------------------------
module hlc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count overflow");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count wrong after pop");

endmodule

// ----- src/hlc_front.sv -----
// ---------------------------------------------------------------------------
// hlc_front
// Accepts segments and evaluates both endpoints against the first plane.
// ---------------------------------------------------------------------------
module hlc_front #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [8*W-1:0]   in_pts,
	input  logic             fifo_full,
	output logic             push,
	output logic [10*W+1:0]  push_data
);
	import hlc_pkg::*;

	localparam int DW   = W + 1;
	localparam int AXIS = plane_axis(0);
	localparam bit MNUS = plane_minus(0);

	logic            f_valid_q;
	logic [8*W-1:0]  f_pts_q;
	logic [DW-1:0]   f_d0_q;
	logic [DW-1:0]   f_d1_q;
	logic            ready;
	logic [DW-1:0]   d0;
	logic [DW-1:0]   d1;
	logic [W-1:0]    s_w;
	logic [W-1:0]    s_c;
	logic [W-1:0]    e_w;
	logic [W-1:0]    e_c;

	assign ready    = !f_valid_q || !fifo_full;
	assign in_stall = !ready;
	assign push     = f_valid_q;

	assign s_w = in_pts[COMP_W*W +: W];
	assign s_c = in_pts[AXIS*W +: W];
	assign e_w = in_pts[(NUM_COMPS + COMP_W)*W +: W];
	assign e_c = in_pts[(NUM_COMPS + AXIS)*W +: W];
	assign d0 = MNUS ? ({s_w[W-1], s_w} - {s_c[W-1], s_c}) : ({s_w[W-1], s_w} + {s_c[W-1], s_c});
	assign d1 = MNUS ? ({e_w[W-1], e_w} - {e_c[W-1], e_c}) : ({e_w[W-1], e_w} + {e_c[W-1], e_c});

	assign push_data = {f_d1_q, f_d0_q, f_pts_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_q <= 1'b0;
		end else if (ready) begin
			f_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && in_valid) begin
			f_pts_q <= in_pts;
			f_d0_q  <= d0;
			f_d1_q  <= d1;
		end
	end

	// hold the segment while the queue is full
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid_q && fifo_full) |=> (f_valid_q && $stable(f_pts_q)))
		else $error("front segment lost while queue full");

endmodule

// ----- src/hlc_plane.sv -----
// ---------------------------------------------------------------------------
// hlc_plane
// Clips a segment against one plane: classify, multiply, pipelined restoring
// divide, replace the outside endpoint, then evaluate the next plane.
// ---------------------------------------------------------------------------
module hlc_plane #(
	parameter int W     = 32,
	parameter int PLANE = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  hlc_pkg::min_den_t min_den,
	input  logic              in_valid,
	input  logic              in_vis,
	input  logic [8*W-1:0]    in_pts,
	input  logic [W:0]        in_d0,
	input  logic [W:0]        in_d1,
	output logic              out_valid,
	output logic              out_vis,
	output logic [8*W-1:0]    out_pts,
	output logic [W:0]        out_d0,
	output logic [W:0]        out_d1
);
	import hlc_pkg::*;

	localparam int DW    = W + 1;
	localparam int MW    = W + 2;
	localparam int QW    = W + 1;
	localparam int PW    = 2 * W + 2;
	localparam int NEXT  = (PLANE + 1) % NUM_PLANES;
	localparam int AXIS  = plane_axis(NEXT);
	localparam bit MNUS  = plane_minus(NEXT);

	// ---- stage 1: classify ----
	logic            n0, n1;
	logic [DW-1:0]   ad0, ad1;
	logic [MW-1:0]   mag;
	logic            below, reject, vis1, clip1;
	logic [DW-1:0]   diff  [NUM_COMPS];
	logic [DW-1:0]   adiff [NUM_COMPS];

	logic            valid_s1, vis_s1, clip_s1, sel_s1;
	logic [8*W-1:0]  pts_s1;
	logic [MW-1:0]   mag_s1;
	logic [DW-1:0]   adist_s1;
	logic [DW-1:0]   adiff_s1 [NUM_COMPS];
	logic [NUM_COMPS-1:0] neg_s1;

	assign n0  = in_d0[DW-1];
	assign n1  = in_d1[DW-1];
	assign ad0 = n0 ? (~in_d0 + 1'b1) : in_d0;
	assign ad1 = n1 ? (~in_d1 + 1'b1) : in_d1;
	assign mag = {1'b0, ad0} + {1'b0, ad1};
	assign below  = mag < {{(MW-MIN_DEN_W){1'b0}}, min_den};
	assign reject = in_vis && ((n0 && n1) || ((n0 ^ n1) && below));
	assign vis1   = in_vis && !reject;
	assign clip1  = vis1 && (n0 ^ n1);

	for (genvar c = 0; c < NUM_COMPS; c++) begin : g_diff
		logic [W-1:0] sc, ec;
		assign sc = in_pts[c*W +: W];
		assign ec = in_pts[(NUM_COMPS + c)*W +: W];
		assign diff[c]  = {ec[W-1], ec} - {sc[W-1], sc};
		assign adiff[c] = diff[c][DW-1] ? (~diff[c] + 1'b1) : diff[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s1   <= vis1;
			clip_s1  <= clip1;
			sel_s1   <= n0;
			pts_s1   <= in_pts;
			mag_s1   <= mag;
			adist_s1 <= ad0;
			for (int c = 0; c < NUM_COMPS; c++) begin
				adiff_s1[c] <= adiff[c];
				neg_s1[c]   <= diff[c][DW-1];
			end
		end
	end

	// ---- stage 2: |diff| * |d0| ----
	logic            valid_s2, vis_s2, clip_s2, sel_s2;
	logic [8*W-1:0]  pts_s2;
	logic [MW-1:0]   mag_s2;
	logic [PW-1:0]   prod_s2 [NUM_COMPS];
	logic [NUM_COMPS-1:0] neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s2  <= vis_s1;
			clip_s2 <= clip_s1;
			sel_s2  <= sel_s1;
			pts_s2  <= pts_s1;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			for (int c = 0; c < NUM_COMPS; c++) begin
				prod_s2[c] <= {{(PW-DW){1'b0}}, adiff_s1[c]} * {{(PW-DW){1'b0}}, adist_s1};
			end
		end
	end

	// ---- divide stages: one quotient bit per stage ----
	logic            valid_sk [1:QW];
	logic            vis_sk   [1:QW];
	logic            clip_sk  [1:QW];
	logic            sel_sk   [1:QW];
	logic [8*W-1:0]  pts_sk   [1:QW];
	logic [MW-1:0]   mag_sk   [1:QW];
	logic [NUM_COMPS-1:0] neg_sk [1:QW];
	logic [QW-1:0]   rem_sk   [1:QW][NUM_COMPS];
	logic [QW-1:0]   num_sk   [1:QW][NUM_COMPS];
	logic [QW-1:0]   quo_sk   [1:QW][NUM_COMPS];

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic            valid_i, vis_i, clip_i, sel_i;
		logic [8*W-1:0]  pts_i;
		logic [MW-1:0]   mag_i;
		logic [NUM_COMPS-1:0] neg_i;
		logic [QW-1:0]   rem_i [NUM_COMPS];
		logic [QW-1:0]   num_i [NUM_COMPS];
		logic [QW-1:0]   quo_i [NUM_COMPS];
		logic [MW-1:0]   trial [NUM_COMPS];
		logic [MW-1:0]   sub   [NUM_COMPS];
		logic            ge    [NUM_COMPS];

		if (k == 0) begin : g_first
			assign valid_i = valid_s2;
			assign vis_i   = vis_s2;
			assign clip_i  = clip_s2;
			assign sel_i   = sel_s2;
			assign pts_i   = pts_s2;
			assign mag_i   = mag_s2;
			assign neg_i   = neg_s2;
			for (genvar c = 0; c < NUM_COMPS; c++) begin : g_lane
				assign rem_i[c] = prod_s2[c][PW-1:QW];
				assign num_i[c] = prod_s2[c][QW-1:0];
				assign quo_i[c] = '0;
			end
		end else begin : g_next
			assign valid_i = valid_sk[k];
			assign vis_i   = vis_sk[k];
			assign clip_i  = clip_sk[k];
			assign sel_i   = sel_sk[k];
			assign pts_i   = pts_sk[k];
			assign mag_i   = mag_sk[k];
			assign neg_i   = neg_sk[k];
			for (genvar c = 0; c < NUM_COMPS; c++) begin : g_lane
				assign rem_i[c] = rem_sk[k][c];
				assign num_i[c] = num_sk[k][c];
				assign quo_i[c] = quo_sk[k][c];
			end
		end

		for (genvar c = 0; c < NUM_COMPS; c++) begin : g_step
			assign trial[c] = {rem_i[c], num_i[c][QW-1]};
			assign ge[c]    = trial[c] >= mag_i;
			assign sub[c]   = ge[c] ? (trial[c] - mag_i) : trial[c];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[k+1] <= 1'b0;
			end else if (en) begin
				valid_sk[k+1] <= valid_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vis_sk[k+1]  <= vis_i;
				clip_sk[k+1] <= clip_i;
				sel_sk[k+1]  <= sel_i;
				pts_sk[k+1]  <= pts_i;
				mag_sk[k+1]  <= mag_i;
				neg_sk[k+1]  <= neg_i;
				for (int c = 0; c < NUM_COMPS; c++) begin
					rem_sk[k+1][c] <= sub[c][QW-1:0];
					num_sk[k+1][c] <= {num_i[c][QW-2:0], 1'b0};
					quo_sk[k+1][c] <= {quo_i[c][QW-2:0], ge[c]};
				end
			end
		end
	end

	// ---- stage 3: apply sign, replace the outside endpoint ----
	logic            valid_s3, vis_s3;
	logic [8*W-1:0]  pts_s3;
	logic [8*W-1:0]  new_pts;

	always_comb begin
		logic [DW-1:0] sq;
		logic [DW-1:0] sum;
		logic [W-1:0]  sc;
		new_pts = pts_sk[QW];
		for (int c = 0; c < NUM_COMPS; c++) begin
			sc  = pts_sk[QW][c*W +: W];
			sq  = neg_sk[QW][c] ? (~quo_sk[QW][c] + 1'b1) : quo_sk[QW][c];
			sum = {sc[W-1], sc} + sq;
			if (clip_sk[QW]) begin
				if (sel_sk[QW]) begin
					new_pts[c*W +: W] = sum[W-1:0];
				end else begin
					new_pts[(NUM_COMPS + c)*W +: W] = sum[W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_sk[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s3 <= vis_sk[QW];
			pts_s3 <= new_pts;
		end
	end

	// ---- stage 4: distances for the next plane ----
	logic            valid_s4, vis_s4;
	logic [8*W-1:0]  pts_s4;
	logic [DW-1:0]   d0_s4, d1_s4;
	logic [W-1:0]    s_w, s_c, e_w, e_c;
	logic [DW-1:0]   nd0, nd1;

	assign s_w = pts_s3[COMP_W*W +: W];
	assign s_c = pts_s3[AXIS*W +: W];
	assign e_w = pts_s3[(NUM_COMPS + COMP_W)*W +: W];
	assign e_c = pts_s3[(NUM_COMPS + AXIS)*W +: W];
	assign nd0 = MNUS ? ({s_w[W-1], s_w} - {s_c[W-1], s_c}) : ({s_w[W-1], s_w} + {s_c[W-1], s_c});
	assign nd1 = MNUS ? ({e_w[W-1], e_w} - {e_c[W-1], e_c}) : ({e_w[W-1], e_w} + {e_c[W-1], e_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s4 <= vis_s3;
			pts_s4 <= pts_s3;
			d0_s4  <= nd0;
			d1_s4  <= nd1;
		end
	end

	assign out_valid = valid_s4;
	assign out_vis   = vis_s4;
	assign out_pts   = pts_s4;
	assign out_d0    = d0_s4;
	assign out_d1    = d1_s4;

	// a segment that already lost visibility never gets clipped
	a_no_clip_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !vis_s1) |-> !clip_s1) else $error("clip on rejected segment");

endmodule

// ----- src/hlc_back.sv -----
// ---------------------------------------------------------------------------
// hlc_back
// Six chained plane stages and the result register.
// ---------------------------------------------------------------------------
module hlc_back #(
	parameter int W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hlc_pkg::min_den_t min_den,
	input  logic              in_valid,
	input  logic [10*W+1:0]   in_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              out_vis,
	output logic [8*W-1:0]    out_pts
);
	import hlc_pkg::*;

	logic            en;
	logic            pv   [NUM_PLANES+1];
	logic            pvis [NUM_PLANES+1];
	logic [8*W-1:0]  ppts [NUM_PLANES+1];
	logic [W:0]      pd0  [NUM_PLANES+1];
	logic [W:0]      pd1  [NUM_PLANES+1];

	logic            out_valid_q;
	logic            out_vis_q;
	logic [8*W-1:0]  out_pts_q;

	// advance the whole pipeline when the result register can take a transaction
	assign en  = !out_valid_q || !out_stall;
	assign pop = en && in_valid;

	assign pv[0]   = in_valid;
	assign pvis[0] = 1'b1;
	assign ppts[0] = in_data[8*W-1:0];
	assign pd0[0]  = in_data[8*W +: W+1];
	assign pd1[0]  = in_data[9*W+1 +: W+1];

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		hlc_plane #(
			.W     (W),
			.PLANE (p)
		) u_plane (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.min_den   (min_den),
			.in_valid  (pv[p]),
			.in_vis    (pvis[p]),
			.in_pts    (ppts[p]),
			.in_d0     (pd0[p]),
			.in_d1     (pd1[p]),
			.out_valid (pv[p+1]),
			.out_vis   (pvis[p+1]),
			.out_pts   (ppts[p+1]),
			.out_d0    (pd0[p+1]),
			.out_d1    (pd1[p+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= pv[NUM_PLANES];
		end
	end

	// drop the coordinates of a rejected segment
	always_ff @(posedge clk) begin
		if (en) begin
			out_vis_q <= pvis[NUM_PLANES];
			out_pts_q <= pvis[NUM_PLANES] ? ppts[NUM_PLANES] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_vis   = out_vis_q;
	assign out_pts   = out_pts_q;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_vis_q) |-> (out_pts_q == '0))
		else $error("rejected segment carries coordinates");

endmodule

// ----- src/homogeneous_line_clipper.sv -----
// Throughput: one segment per cycle while out_stall does not hold the pipeline;
// each plane divides in pipelined stages, one quotient bit per stage.
// A four-entry queue sits between the front end and the six-plane clip pipeline.
// Reset clears all valid flags and the queue; min_denominator resets to 1.
// ---------------------------------------------------------------------------
// homogeneous_line_clipper
// Clips a clip-space segment against the six homogeneous view planes.
// ---------------------------------------------------------------------------
module homogeneous_line_clipper #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  hlc_pkg::min_den_t      cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] start_x,
	input  logic [COORD_WIDTH-1:0] start_y,
	input  logic [COORD_WIDTH-1:0] start_z,
	input  logic [COORD_WIDTH-1:0] start_w,
	input  logic [COORD_WIDTH-1:0] end_x,
	input  logic [COORD_WIDTH-1:0] end_y,
	input  logic [COORD_WIDTH-1:0] end_z,
	input  logic [COORD_WIDTH-1:0] end_w,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   visible,
	output logic [COORD_WIDTH-1:0] out_start_x,
	output logic [COORD_WIDTH-1:0] out_start_y,
	output logic [COORD_WIDTH-1:0] out_start_z,
	output logic [COORD_WIDTH-1:0] out_start_w,
	output logic [COORD_WIDTH-1:0] out_end_x,
	output logic [COORD_WIDTH-1:0] out_end_y,
	output logic [COORD_WIDTH-1:0] out_end_z,
	output logic [COORD_WIDTH-1:0] out_end_w
);
	import hlc_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int QD_W = 10 * W + 2;

	min_den_t          min_den_q;
	logic [8*W-1:0]    in_pts;
	logic [8*W-1:0]    res_pts;
	logic              push, full, empty, pop;
	logic [QD_W-1:0]   push_data;
	logic [QD_W-1:0]   pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_den_q <= MIN_DEN_RESET;
		end else if (cfg_we) begin
			min_den_q <= cfg_wdata;
		end
	end

	assign in_pts = {end_w, end_z, end_y, end_x, start_w, start_z, start_y, start_x};

	hlc_front #(
		.W (W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_pts    (in_pts),
		.fifo_full (full),
		.push      (push),
		.push_data (push_data)
	);

	hlc_fifo #(
		.WIDTH (QD_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	hlc_back #(
		.W (W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_den   (min_den_q),
		.in_valid  (!empty),
		.in_data   (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_vis   (visible),
		.out_pts   (res_pts)
	);

	assign out_start_x = res_pts[0*W +: W];
	assign out_start_y = res_pts[1*W +: W];
	assign out_start_z = res_pts[2*W +: W];
	assign out_start_w = res_pts[3*W +: W];
	assign out_end_x   = res_pts[4*W +: W];
	assign out_end_y   = res_pts[5*W +: W];
	assign out_end_z   = res_pts[6*W +: W];
	assign out_end_w   = res_pts[7*W +: W];

endmodule
